/* hdl/tmd_pkg.sv */
// Shared types, constants and arithmetic step functions for the TRS matrix decomposition block.
// No dependencies; every other file of the block imports this package.
package tmd_pkg;

    localparam int DW        = 32;          // width of matrix and translation words
    localparam int QF        = 30;          // fraction bits of normalized values
    localparam int SCALE_W   = DW - 1;      // width of the scale outputs
    localparam int VW        = DW + 3;      // width of the unnormalized quaternion vector
    localparam int RAD_W     = 2 * DW;      // width of square-root radicands and dividends
    localparam int ROOT_W    = DW;          // width of a square-root result
    localparam int QUO_W     = QF + 1;      // width of a quotient, at most 1.0 in Q2.30
    localparam int ISQ_STEPS = ROOT_W;      // one root bit per pipeline stage
    localparam int DIV_STEPS = QUO_W;       // one quotient bit per pipeline stage
    localparam int QUE_DEPTH = 4;
    localparam int QUE_AW    = $clog2(QUE_DEPTH);

    localparam logic [DW-1:0]      ONE_Q     = DW'(64'd1 << QF);
    localparam logic [SCALE_W-1:0] SCALE_MAX = '1;

    // Values that ride along with an item and do not take part in the rotation math.
    typedef struct packed {
        logic [2:0][DW-1:0]      trans;
        logic [2:0][SCALE_W-1:0] scale;
        logic                    bad;
    } t_side;

    // One word handed from the front end to the back end through the queue.
    typedef struct packed {
        t_side              side;
        logic [3:0][VW-1:0] v;
    } t_mid;

    typedef struct packed {
        logic [RAD_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqs;

    typedef struct packed {
        logic [RAD_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } t_dvs;

    // One bit of an integer square root; rem holds the radicand minus root squared.
    function automatic t_sqs isqrt_step(input t_sqs cur, input int b);
        t_sqs             nxt;
        logic [RAD_W+1:0] trial;
        trial = ((RAD_W+2)'(cur.root) << (b + 1)) | ((RAD_W+2)'(1) << (2 * b));
        nxt   = cur;
        if ((RAD_W+2)'(cur.rem) >= trial) begin
            nxt.rem  = cur.rem - trial[RAD_W-1:0];
            nxt.root = cur.root | (ROOT_W'(1) << b);
        end
        return nxt;
    endfunction

    // One bit of a restoring division; the quotient must stay below 2^QUO_W.
    function automatic t_dvs div_step(input t_dvs cur, input logic [ROOT_W-1:0] d, input int b);
        t_dvs             nxt;
        logic [RAD_W-1:0] dsh;
        dsh = RAD_W'(d) << b;
        nxt = cur;
        if (cur.rem >= dsh) begin
            nxt.rem = cur.rem - dsh;
            nxt.quo = cur.quo | (QUO_W'(1) << b);
        end
        return nxt;
    endfunction

endpackage

/* hdl/tmd_ifs.sv */
// Handshake interfaces for the matrix input channel and the decomposition result channel.
// Depends on tmd_pkg for the word widths.
interface tmd_in_if import tmd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] r0c0, r0c1, r0c2;
    logic signed [DW-1:0] r1c0, r1c1, r1c2;
    logic signed [DW-1:0] r2c0, r2c1, r2c2;
    logic signed [DW-1:0] in_tx, in_ty, in_tz;

    modport source (output valid, r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2,
                    in_tx, in_ty, in_tz, input ready);
    modport sink   (input valid, r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2,
                    in_tx, in_ty, in_tz, output ready);
endinterface

interface tmd_out_if import tmd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] trans_x, trans_y, trans_z;
    logic [SCALE_W-1:0]   scale_x, scale_y, scale_z;
    logic signed [DW-1:0] quat_x, quat_y, quat_z, quat_w;
    logic                 status;

    modport source (output valid, trans_x, trans_y, trans_z, scale_x, scale_y, scale_z,
                    quat_x, quat_y, quat_z, quat_w, status, input ready);
    modport sink   (input valid, trans_x, trans_y, trans_z, scale_x, scale_y, scale_z,
                    quat_x, quat_y, quat_z, quat_w, status, output ready);
endinterface

/* hdl/tmd_front.sv */
// Front end: row lengths, normalized rotation rows and branch selection of the quaternion method.
// Depends on tmd_pkg and tmd_ifs; feeds tmd_queue.
module tmd_front import tmd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tmd_in_if.sink i_mat,
    output t_mid   o_mid,
    output logic   o_mid_vld,
    input  logic   i_mid_rdy
);

    typedef struct packed {
        logic [8:0][DW-1:0] mag;
        logic [8:0]         neg;
        logic [2:0][DW-1:0] trans;
    } t_car;

    typedef struct packed {
        logic [8:0]         neg;
        logic [2:0][DW-1:0] trans;
        logic [2:0][DW-1:0] len;
    } t_dcar;

    localparam logic signed [VW-1:0] ONE_V = VW'(ONE_Q);

    logic               en;
    logic [8:0][DW-1:0] w_m;
    logic               r_f_vld;

    assign en          = !r_f_vld || i_mid_rdy;
    assign i_mat.ready = en;
    assign o_mid_vld   = r_f_vld;

    assign w_m[0] = i_mat.r0c0;
    assign w_m[1] = i_mat.r0c1;
    assign w_m[2] = i_mat.r0c2;
    assign w_m[3] = i_mat.r1c0;
    assign w_m[4] = i_mat.r1c1;
    assign w_m[5] = i_mat.r1c2;
    assign w_m[6] = i_mat.r2c0;
    assign w_m[7] = i_mat.r2c1;
    assign w_m[8] = i_mat.r2c2;

    // Stage A: magnitudes and signs.
    logic r_a_vld;
    t_car r_a, n_a;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_a.neg[k] = w_m[k][DW-1];
            n_a.mag[k] = w_m[k][DW-1] ? (~w_m[k] + 1'b1) : w_m[k];
        end
        n_a.trans[0] = i_mat.in_tx;
        n_a.trans[1] = i_mat.in_ty;
        n_a.trans[2] = i_mat.in_tz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_mat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= n_a;
        end
    end

    // Stage B: squares of all nine elements.
    logic                  r_b_vld;
    t_car                  r_b;
    logic [8:0][RAD_W-1:0] r_b_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b <= r_a;
            for (int k = 0; k < 9; k++) begin
                r_b_sq[k] <= RAD_W'(r_a.mag[k]) * RAD_W'(r_a.mag[k]);
            end
        end
    end

    // Stage C: row sums of squares.
    logic                  r_c_vld;
    t_car                  r_c;
    logic [2:0][RAD_W-1:0] r_c_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c <= r_b;
            for (int i = 0; i < 3; i++) begin
                r_c_sum[i] <= r_b_sq[3*i] + r_b_sq[3*i+1] + r_b_sq[3*i+2];
            end
        end
    end

    // Row lengths, one root bit per stage, three rows side by side.
    t_sqs r_sq     [ISQ_STEPS][3];
    t_car r_sq_c   [ISQ_STEPS];
    logic r_sq_vld [ISQ_STEPS];

    for (genvar s = 0; s < ISQ_STEPS; s++) begin : g_sq
        t_sqs w_in [3];
        t_car w_c;
        logic w_v;

        if (s == 0) begin : g_head
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    w_in[i].rem  = r_c_sum[i];
                    w_in[i].root = '0;
                end
            end
            assign w_c = r_c;
            assign w_v = r_c_vld;
        end else begin : g_tail
            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    w_in[i] = r_sq[s-1][i];
                end
            end
            assign w_c = r_sq_c[s-1];
            assign w_v = r_sq_vld[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[s] <= 1'b0;
            end else if (en) begin
                r_sq_vld[s] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    r_sq[s][i] <= isqrt_step(w_in[i], ISQ_STEPS - 1 - s);
                end
                r_sq_c[s] <= w_c;
            end
        end
    end

    // Element magnitudes divided by their row lengths, one quotient bit per stage.
    t_dvs  r_dv     [DIV_STEPS][9];
    t_dcar r_dv_c   [DIV_STEPS];
    logic  r_dv_vld [DIV_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_dv
        t_dvs  w_in [9];
        t_dcar w_c;
        logic  w_v;

        if (s == 0) begin : g_head
            always_comb begin
                for (int k = 0; k < 9; k++) begin
                    w_in[k].rem = {{(RAD_W-DW-QF){1'b0}}, r_sq_c[ISQ_STEPS-1].mag[k], {QF{1'b0}}};
                    w_in[k].quo = '0;
                end
                w_c.neg   = r_sq_c[ISQ_STEPS-1].neg;
                w_c.trans = r_sq_c[ISQ_STEPS-1].trans;
                for (int i = 0; i < 3; i++) begin
                    w_c.len[i] = r_sq[ISQ_STEPS-1][i].root;
                end
            end
            assign w_v = r_sq_vld[ISQ_STEPS-1];
        end else begin : g_tail
            always_comb begin
                for (int k = 0; k < 9; k++) begin
                    w_in[k] = r_dv[s-1][k];
                end
            end
            assign w_c = r_dv_c[s-1];
            assign w_v = r_dv_vld[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[s] <= 1'b0;
            end else if (en) begin
                r_dv_vld[s] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        r_dv[s][3*i+j] <= div_step(w_in[3*i+j], w_c.len[i], DIV_STEPS - 1 - s);
                    end
                end
                r_dv_c[s] <= w_c;
            end
        end
    end

    // Stage D: signed normalized elements, scales and the zero-length flag.
    logic               r_d_vld;
    logic [8:0][DW-1:0] r_d_n, n_d_n;
    t_side              r_d_side, n_d_side;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_d_n[k] = {1'b0, r_dv[DIV_STEPS-1][k].quo};
            if (r_dv_c[DIV_STEPS-1].neg[k]) begin
                n_d_n[k] = -n_d_n[k];
            end
        end
        n_d_side.trans = r_dv_c[DIV_STEPS-1].trans;
        n_d_side.bad   = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n_d_side.scale[i] = r_dv_c[DIV_STEPS-1].len[i][DW-1] ?
                                SCALE_MAX : r_dv_c[DIV_STEPS-1].len[i][SCALE_W-1:0];
            if (r_dv_c[DIV_STEPS-1].len[i] == '0) begin
                n_d_side.bad = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= r_dv_vld[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_n    <= n_d_n;
            r_d_side <= n_d_side;
        end
    end

    // Stage E: trace and diagonal comparisons that pick the branch.
    logic                   r_e_vld;
    logic [8:0][DW-1:0]     r_e_n;
    t_side                  r_e_side;
    logic signed [DW+1:0]   r_e_t, n_e_t;
    logic                   r_e_tpos, r_e_c0, r_e_c1;

    assign n_e_t = (DW+2)'($signed(r_d_n[0])) + (DW+2)'($signed(r_d_n[4]))
                 + (DW+2)'($signed(r_d_n[8]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_n    <= r_d_n;
            r_e_side <= r_d_side;
            r_e_t    <= n_e_t;
            r_e_tpos <= n_e_t > 0;
            r_e_c0   <= ($signed(r_d_n[0]) > $signed(r_d_n[4]))
                     && ($signed(r_d_n[0]) > $signed(r_d_n[8]));
            r_e_c1   <= $signed(r_d_n[4]) > $signed(r_d_n[8]);
        end
    end

    // Stage F: the unnormalized quaternion of the chosen branch.
    logic signed [VW-1:0] e [9];
    logic signed [VW-1:0] s_arg;
    t_mid                 n_f, r_f;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            e[k] = VW'($signed(r_e_n[k]));
        end
        priority if (r_e_tpos) begin
            s_arg = ONE_V + VW'(r_e_t);
        end else if (r_e_c0) begin
            s_arg = ONE_V + e[0] - e[4] - e[8];
        end else if (r_e_c1) begin
            s_arg = ONE_V + e[4] - e[0] - e[8];
        end else begin
            s_arg = ONE_V + e[8] - e[0] - e[4];
        end
        if (s_arg <= 0) begin
            s_arg = VW'(1);
        end

        n_f.side = r_e_side;
        priority if (r_e_tpos) begin
            n_f.v[0] = e[5] - e[7];
            n_f.v[1] = e[6] - e[2];
            n_f.v[2] = e[1] - e[3];
            n_f.v[3] = s_arg;
        end else if (r_e_c0) begin
            n_f.v[0] = s_arg;
            n_f.v[1] = e[3] + e[1];
            n_f.v[2] = e[6] + e[2];
            n_f.v[3] = e[5] - e[7];
        end else if (r_e_c1) begin
            n_f.v[0] = e[3] + e[1];
            n_f.v[1] = s_arg;
            n_f.v[2] = e[7] + e[5];
            n_f.v[3] = e[6] - e[2];
        end else begin
            n_f.v[0] = e[6] + e[2];
            n_f.v[1] = e[7] + e[5];
            n_f.v[2] = s_arg;
            n_f.v[3] = e[1] - e[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f <= n_f;
        end
    end

    assign o_mid = r_f;

endmodule

/* hdl/tmd_queue.sv */
// Short first-in first-out queue between the front end and the back end.
// Depends on tmd_pkg for the word type and depth.
module tmd_queue import tmd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_mid i_push_dat,
    input  logic i_push_vld,
    output logic o_push_rdy,
    output t_mid o_pop_dat,
    output logic o_pop_vld,
    input  logic i_pop_rdy
);

    t_mid              r_mem [QUE_DEPTH];
    logic [QUE_AW-1:0] r_wp, r_rp;
    logic [QUE_AW:0]   r_cnt;
    logic              push, pop;

    assign o_push_rdy = r_cnt != (QUE_AW+1)'(QUE_DEPTH);
    assign o_pop_vld  = r_cnt != '0;
    assign o_pop_dat  = r_mem[r_rp];
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = o_pop_vld && i_pop_rdy;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_dat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* hdl/tmd_back.sv */
// Back end: scales the quaternion vector, takes its length and divides it down to unit length.
// Depends on tmd_pkg and tmd_ifs; fed from tmd_queue.
module tmd_back import tmd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_mid      i_mid,
    input  logic      i_mid_vld,
    output logic      o_mid_rdy,
    tmd_out_if.source o_res
);

    localparam int MAG_W = QF + 3;

    typedef struct packed {
        t_side              side;
        logic [3:0]         neg;
        logic [3:0][QF-1:0] w;
    } t_bcar;

    logic en;
    logic r_o_vld;

    assign en        = !r_o_vld || o_res.ready;
    assign o_mid_rdy = en;

    // Stage G: magnitudes and signs of the vector.
    logic                  r_g_vld;
    t_bcar                 r_g, n_g;
    logic [3:0][MAG_W-1:0] r_g_mag, n_g_mag;
    logic [VW-1:0]         g_abs [4];

    always_comb begin
        n_g.side = i_mid.side;
        n_g.w    = '0;
        for (int i = 0; i < 4; i++) begin
            n_g.neg[i] = i_mid.v[i][VW-1];
            g_abs[i]   = i_mid.v[i][VW-1] ? -i_mid.v[i] : i_mid.v[i];
            n_g_mag[i] = g_abs[i][MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else if (en) begin
            r_g_vld <= i_mid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g     <= n_g;
            r_g_mag <= n_g_mag;
        end
    end

    // Stage H: shift all four down by the same amount until they fit in QF bits.
    logic        r_h_vld;
    t_bcar       r_h, n_h;
    logic        any2, any1, any0;
    logic [1:0]  h_k;
    logic [MAG_W-1:0] h_sh [4];

    always_comb begin
        any2 = 1'b0;
        any1 = 1'b0;
        any0 = 1'b0;
        for (int i = 0; i < 4; i++) begin
            any2 = any2 | r_g_mag[i][QF+2];
            any1 = any1 | r_g_mag[i][QF+1];
            any0 = any0 | r_g_mag[i][QF];
        end
        priority if (any2) begin
            h_k = 2'd3;
        end else if (any1) begin
            h_k = 2'd2;
        end else if (any0) begin
            h_k = 2'd1;
        end else begin
            h_k = 2'd0;
        end
        n_h = r_g;
        for (int i = 0; i < 4; i++) begin
            h_sh[i]  = r_g_mag[i] >> h_k;
            n_h.w[i] = h_sh[i][QF-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else if (en) begin
            r_h_vld <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h <= n_h;
        end
    end

    // Stage I: squares.
    logic                   r_i_vld;
    t_bcar                  r_i;
    logic [3:0][2*QF-1:0]   r_i_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_vld <= 1'b0;
        end else if (en) begin
            r_i_vld <= r_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i <= r_h;
            for (int i = 0; i < 4; i++) begin
                r_i_sq[i] <= (2*QF)'(r_h.w[i]) * (2*QF)'(r_h.w[i]);
            end
        end
    end

    // Stage J: sum of squares.
    logic             r_j_vld;
    t_bcar            r_j;
    logic [RAD_W-1:0] r_j_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_vld <= 1'b0;
        end else if (en) begin
            r_j_vld <= r_i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_j     <= r_i;
            r_j_sum <= RAD_W'(r_i_sq[0]) + RAD_W'(r_i_sq[1])
                     + RAD_W'(r_i_sq[2]) + RAD_W'(r_i_sq[3]);
        end
    end

    // Vector length, one root bit per stage.
    t_sqs  r_sq     [ISQ_STEPS];
    t_bcar r_sq_c   [ISQ_STEPS];
    logic  r_sq_vld [ISQ_STEPS];

    for (genvar s = 0; s < ISQ_STEPS; s++) begin : g_sq
        t_sqs  w_in;
        t_bcar w_c;
        logic  w_v;

        if (s == 0) begin : g_head
            assign w_in.rem  = r_j_sum;
            assign w_in.root = '0;
            assign w_c       = r_j;
            assign w_v       = r_j_vld;
        end else begin : g_tail
            assign w_in = r_sq[s-1];
            assign w_c  = r_sq_c[s-1];
            assign w_v  = r_sq_vld[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[s] <= 1'b0;
            end else if (en) begin
                r_sq_vld[s] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq[s]   <= isqrt_step(w_in, ISQ_STEPS - 1 - s);
                r_sq_c[s] <= w_c;
            end
        end
    end

    // Components divided by the length, one quotient bit per stage.
    t_dvs              r_dv     [DIV_STEPS][4];
    logic [ROOT_W-1:0] r_dv_d   [DIV_STEPS];
    t_bcar             r_dv_c   [DIV_STEPS];
    logic              r_dv_vld [DIV_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_dv
        t_dvs              w_in [4];
        logic [ROOT_W-1:0] w_d;
        t_bcar             w_c;
        logic              w_v;

        if (s == 0) begin : g_head
            always_comb begin
                for (int i = 0; i < 4; i++) begin
                    w_in[i].rem = {{(RAD_W-2*QF){1'b0}}, r_sq_c[ISQ_STEPS-1].w[i], {QF{1'b0}}};
                    w_in[i].quo = '0;
                end
                // An all-zero vector divides by one so the quotients come out zero.
                w_d = (r_sq[ISQ_STEPS-1].root == '0) ? ROOT_W'(1) : r_sq[ISQ_STEPS-1].root;
            end
            assign w_c = r_sq_c[ISQ_STEPS-1];
            assign w_v = r_sq_vld[ISQ_STEPS-1];
        end else begin : g_tail
            always_comb begin
                for (int i = 0; i < 4; i++) begin
                    w_in[i] = r_dv[s-1][i];
                end
                w_d = r_dv_d[s-1];
            end
            assign w_c = r_dv_c[s-1];
            assign w_v = r_dv_vld[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[s] <= 1'b0;
            end else if (en) begin
                r_dv_vld[s] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int i = 0; i < 4; i++) begin
                    r_dv[s][i] <= div_step(w_in[i], w_d, DIV_STEPS - 1 - s);
                end
                r_dv_d[s] <= w_d;
                r_dv_c[s] <= w_c;
            end
        end
    end

    // Output register: signs restored, identity on a zero-length row.
    t_side              r_o_side;
    logic [3:0][DW-1:0] r_o_q, n_o_q;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_o_q[i] = {1'b0, r_dv[DIV_STEPS-1][i].quo};
            if (r_dv_c[DIV_STEPS-1].neg[i]) begin
                n_o_q[i] = -n_o_q[i];
            end
        end
        if (r_dv_c[DIV_STEPS-1].side.bad) begin
            n_o_q[0] = '0;
            n_o_q[1] = '0;
            n_o_q[2] = '0;
            n_o_q[3] = ONE_Q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_dv_vld[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_side <= r_dv_c[DIV_STEPS-1].side;
            r_o_q    <= n_o_q;
        end
    end

    assign o_res.valid   = r_o_vld;
    assign o_res.trans_x = r_o_side.trans[0];
    assign o_res.trans_y = r_o_side.trans[1];
    assign o_res.trans_z = r_o_side.trans[2];
    assign o_res.scale_x = r_o_side.scale[0];
    assign o_res.scale_y = r_o_side.scale[1];
    assign o_res.scale_z = r_o_side.scale[2];
    assign o_res.quat_x  = r_o_q[0];
    assign o_res.quat_y  = r_o_q[1];
    assign o_res.quat_z  = r_o_q[2];
    assign o_res.quat_w  = r_o_q[3];
    assign o_res.status  = r_o_side.bad;

endmodule

/* hdl/trs_matrix_decomposition_unit.sv */
// Splits an affine matrix into translation, per-row scale and a unit rotation quaternion.
// Usage: i_mat carries one word per matrix, the upper 3x3 block by rows plus the
// translation, all signed Q16.16. o_res returns one word per matrix: the translation
// as given, each row's Euclidean length as scale (saturating at the top of its range),
// the rotation quaternion in signed Q2.30 and a status bit that is set when a row has
// zero length, in which case the quaternion is the identity.
// Throughput is one matrix per clock cycle when nothing stalls. From acceptance to o_res.valid
// a matrix passes the front end (three setup stages, a 32-stage square root and a
// 31-stage divider, three branch stages), the queue and the back end (four stages,
// again a 32-stage square root and a 31-stage divider, and the output register).
// The root and divider pipelines resolve one bit per stage.
// When o_res.ready is low the back end holds, the four-word queue absorbs the front
// end's output, and i_mat.ready falls once the queue is full and the front end's last
// stage is occupied. Words already in flight are never dropped.
// Reset is synchronous and active low; it empties the pipelines and the queue. There
// is no configuration and no state that carries from one matrix to the next.
// Depends on tmd_pkg, tmd_ifs, tmd_front, tmd_queue and tmd_back.
module trs_matrix_decomposition_unit import tmd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tmd_in_if.sink    i_mat,
    tmd_out_if.source o_res
);

    // Front end to queue.
    t_mid f_dat;
    logic f_vld;
    logic f_rdy;

    // Queue to back end.
    t_mid b_dat;
    logic b_vld;
    logic b_rdy;

    tmd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mat     (i_mat),
        .o_mid     (f_dat),
        .o_mid_vld (f_vld),
        .i_mid_rdy (f_rdy)
    );

    tmd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_dat (f_dat),
        .i_push_vld (f_vld),
        .o_push_rdy (f_rdy),
        .o_pop_dat  (b_dat),
        .o_pop_vld  (b_vld),
        .i_pop_rdy  (b_rdy)
    );

    tmd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mid     (b_dat),
        .i_mid_vld (b_vld),
        .o_mid_rdy (b_rdy),
        .o_res     (o_res)
    );

endmodule
